// File: rtl/assert_macros.svh
// Assertion helper macros shared by the RTL of the service-data extractor.
// Each macro checks on the rising edge of clk and is muted while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the cycle after.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/asde_pkg.sv
// Shared types and constants for the advertising service-data extractor.
// No dependencies; used by asde_walk and adv_service_data_extractor.
`default_nettype none

package asde_pkg;

    // Service-data structure selection.
    localparam logic [7:0] SD_TYPE    = 8'h16;
    localparam logic [7:0] SD_MIN_LEN = 8'd18;
    localparam int         CAP_BYTES  = 14;
    localparam int         CAP_BITS   = 8 * CAP_BYTES;

    // Register reset values.
    localparam logic [15:0] RST_TARGET_UUID      = 16'h3412;
    localparam logic [15:0] RST_TARGET_DEVICE_ID = 16'hCAFE;
    localparam logic [7:0]  RST_MIN_REPORT_LEN   = 8'd30;

    // Register index (paddr[3:2]).
    typedef enum logic [1:0] {
        REG_TARGET_UUID      = 2'd0,
        REG_TARGET_DEVICE_ID = 2'd1,
        REG_MIN_REPORT_LEN   = 2'd2
    } reg_idx_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_MATCH     = 2'd0,
        STATUS_NO_MATCH  = 2'd1,
        STATUS_TOO_SHORT = 2'd2
    } status_t;

    // One byte step handed to the structure walker.
    typedef struct packed {
        logic       en;     // byte advances the walk
        logic       clear;  // report ends with this byte
        logic [7:0] data;
    } walk_step_t;

    // Match targets.
    typedef struct packed {
        logic [15:0] uuid;
        logic [15:0] dev_id;
    } walk_cfg_t;

    // Walker view after the current byte, before any end-of-report clear.
    typedef struct packed {
        logic                matched;
        logic [CAP_BITS-1:0] fields;   // device ID in the top bits, speed at the bottom
    } walk_res_t;

endpackage

`default_nettype wire

// File: rtl/asde_walk.sv
// Length-type structure walker: tracks offsets, qualifies service-data structures
// and latches the captured bytes of the first match. Depends on asde_pkg.
`default_nettype none

module asde_walk
    import asde_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire walk_step_t step,
    input  wire walk_cfg_t  cfg,
    output walk_res_t       res
);

    logic [7:0]          offset_reg, offset_next;
    logic [7:0]          length_reg, length_next;
    logic                stopped_reg, stopped_next;
    logic                qual_reg, qual_next;
    logic                match_reg, match_next;
    logic [7:0]          uuid_lo_reg, uuid_lo_next;
    logic [7:0]          cap_reg [CAP_BYTES];
    logic [CAP_BITS-1:0] latched_reg, latched_next;
    logic [CAP_BITS-1:0] cap_flat;
    logic                match_walk;
    logic                cap_we;
    logic [3:0]          cap_idx;
    logic [7:0]          cap_off;
    logic                qual_tmp;

    // Captured bytes flattened big-endian, first captured byte highest.
    always_comb
    begin
        for (int i = 0; i < CAP_BYTES; i++)
        begin
            cap_flat[8*(CAP_BYTES-1-i) +: 8] = cap_reg[i];
        end
    end

    assign cap_off = offset_reg - 8'd4;
    assign cap_idx = cap_off[3:0];

    // Walk one byte.
    always_comb
    begin
        offset_next  = offset_reg;
        length_next  = length_reg;
        stopped_next = stopped_reg;
        qual_next    = qual_reg;
        uuid_lo_next = uuid_lo_reg;
        latched_next = latched_reg;
        match_walk   = match_reg;
        cap_we       = 1'b0;
        qual_tmp     = qual_reg;

        if (step.en && !stopped_reg && !match_reg)
        begin
            if (offset_reg == 8'd0)
            begin
                if (step.data == 8'd0)
                begin
                    stopped_next = 1'b1;
                end
                else
                begin
                    length_next = step.data;
                    offset_next = 8'd1;
                    qual_next   = 1'b0;
                end
            end
            else
            begin
                if (offset_reg == 8'd1)
                begin
                    qual_tmp = (step.data == SD_TYPE) && (length_reg >= SD_MIN_LEN);
                end
                if (offset_reg == 8'd2)
                begin
                    uuid_lo_next = step.data;
                end
                if (offset_reg == 8'd3 && {step.data, uuid_lo_reg} != cfg.uuid)
                begin
                    qual_tmp = 1'b0;
                end
                if (offset_reg >= 8'd4 && offset_reg < 8'(4 + CAP_BYTES))
                begin
                    cap_we = 1'b1;
                end
                if (offset_reg == 8'd5 && {cap_reg[0], step.data} != cfg.dev_id)
                begin
                    qual_tmp = 1'b0;
                end
                // A qualifying structure has at least 18 bytes, so all captured
                // bytes are already stored when its last byte arrives.
                if (offset_reg == length_reg)
                begin
                    if (qual_tmp)
                    begin
                        match_walk   = 1'b1;
                        latched_next = cap_flat;
                    end
                    offset_next = 8'd0;
                    qual_tmp    = 1'b0;
                end
                else
                begin
                    offset_next = offset_reg + 8'd1;
                end
                qual_next = qual_tmp;
            end
        end

        match_next = match_walk;

        // End of report returns the walk to its start.
        if (step.clear)
        begin
            offset_next  = 8'd0;
            length_next  = 8'd0;
            stopped_next = 1'b0;
            qual_next    = 1'b0;
            match_next   = 1'b0;
        end
    end

    assign res.matched = match_walk;
    assign res.fields  = latched_next;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= 8'd0;
            length_reg  <= 8'd0;
            stopped_reg <= 1'b0;
            qual_reg    <= 1'b0;
            match_reg   <= 1'b0;
        end
        else
        begin
            offset_reg  <= offset_next;
            length_reg  <= length_next;
            stopped_reg <= stopped_next;
            qual_reg    <= qual_next;
            match_reg   <= match_next;
        end
    end

    // Payload bytes; only read once a structure has fully rewritten them.
    always_ff @(posedge clk)
    begin
        uuid_lo_reg <= uuid_lo_next;
        latched_reg <= latched_next;
        if (cap_we)
        begin
            cap_reg[cap_idx] <= step.data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/adv_service_data_extractor.sv
// Advertising service-data extractor top level; uses asde_pkg, asde_walk, assert_macros.svh.
// Path: an accepted last byte is held in the input register and then loads the result
// register, from which its result word can be taken.
// Throughput: one byte word per cycle; only a last byte stalls, while an unread result waits.
// Reset: rst_n is asynchronous, active low; it clears the walk, the byte count and both
// valid flags and loads the register reset values.
`default_nettype none
`include "assert_macros.svh"

module adv_service_data_extractor
    import asde_pkg::*;
#(
    parameter int MAX_REPORT_BYTES = 255
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Input byte stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // [7:0] data_byte, [15:8] signal_strength
    input  wire logic         s_axis_tlast,   // last_byte
    // Result stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata,   // [1:0] match_status, [17:2] dev_id,
                                              // [49:18] latitude_microdeg,
                                              // [81:50] longitude_microdeg,
                                              // [97:82] altitude_m, [113:98] speed_cm_per_s,
                                              // [121:114] rssi_dbm, [127:122] zero
    // Configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0]  target_uuid_reg;
    logic [15:0]  target_dev_reg;
    logic [7:0]   min_len_reg;
    logic         cfg_wr;

    logic         in_vld_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic [7:0]   in_rssi_reg;

    logic [7:0]   pos_reg, pos_next, pos_inc;
    logic         proc_go;
    logic         proc_fire;
    logic         walk_open;

    walk_step_t   step;
    walk_cfg_t    wcfg;
    walk_res_t    wres;

    status_t      status;
    logic         give;
    logic [15:0]  res_dev;
    logic [31:0]  res_lat;
    logic [31:0]  res_lon;
    logic [15:0]  res_alt;
    logic [15:0]  res_speed;

    logic         out_vld_reg;
    logic [127:0] out_data_reg;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_uuid_reg <= RST_TARGET_UUID;
            target_dev_reg  <= RST_TARGET_DEVICE_ID;
            min_len_reg     <= RST_MIN_REPORT_LEN;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_TARGET_UUID:      target_uuid_reg <= pwdata[15:0];
                REG_TARGET_DEVICE_ID: target_dev_reg  <= pwdata[15:0];
                REG_MIN_REPORT_LEN:   min_len_reg     <= pwdata[7:0];
                default:              ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_TARGET_UUID:      prdata = {16'd0, target_uuid_reg};
            REG_TARGET_DEVICE_ID: prdata = {16'd0, target_dev_reg};
            REG_MIN_REPORT_LEN:   prdata = {24'd0, min_len_reg};
            default:              prdata = 32'd0;
        endcase
    end

    // The processing stage stalls only when it holds a last byte and the
    // result register cannot take the new result.
    assign proc_go       = !in_last_reg || !out_vld_reg || m_axis_tready;
    assign proc_fire     = in_vld_reg && proc_go;
    assign s_axis_tready = !in_vld_reg || proc_go;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata[7:0];
            in_last_reg <= s_axis_tlast;
            in_rssi_reg <= s_axis_tdata[15:8];
        end
    end

    // Byte count, saturating at 255.
    assign walk_open = pos_reg < 8'(MAX_REPORT_BYTES);
    assign pos_inc   = (pos_reg == 8'hFF) ? pos_reg : pos_reg + 8'd1;

    always_comb
    begin
        pos_next = pos_reg;
        if (proc_fire)
        begin
            pos_next = in_last_reg ? 8'd0 : pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // Structure walker.
    assign step.en         = proc_fire && walk_open;
    assign step.clear      = proc_fire && in_last_reg;
    assign step.data       = in_byte_reg;
    assign wcfg.uuid       = target_uuid_reg;
    assign wcfg.dev_id     = target_dev_reg;

    asde_walk u_walk
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cfg   (wcfg),
        .res   (wres)
    );

    // Result assembly for the report's last byte.
    always_comb
    begin
        if (pos_inc < min_len_reg)
        begin
            status = STATUS_TOO_SHORT;
        end
        else if (wres.matched)
        begin
            status = STATUS_MATCH;
        end
        else
        begin
            status = STATUS_NO_MATCH;
        end
    end

    assign give      = (status == STATUS_MATCH);
    assign res_dev   = give ? wres.fields[111:96] : 16'd0;
    assign res_lat   = give ? wres.fields[95:64]  : 32'd0;
    assign res_lon   = give ? wres.fields[63:32]  : 32'd0;
    assign res_alt   = give ? wres.fields[31:16]  : 16'd0;
    assign res_speed = give ? wres.fields[15:0]   : 16'd0;

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (proc_fire && in_last_reg)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_last_reg)
        begin
            out_data_reg <= {6'd0, in_rssi_reg, res_speed, res_alt,
                             res_lon, res_lat, res_dev, status};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // Payload is zero unless the report matched.
    `ASSERT_SAME(a_zero_unless_match,
        out_vld_reg && (out_data_reg[1:0] != STATUS_MATCH),
        out_data_reg[113:2] == 112'd0,
        "payload not zero on an unmatched result")

    // Status code is always one of the three defined outcomes.
    `ASSERT_SAME(a_status_code,
        out_vld_reg,
        out_data_reg[1:0] != 2'd3,
        "undefined result status")

    // A processed last byte restarts the byte count.
    `ASSERT_NEXT(a_count_restart,
        proc_fire && in_last_reg,
        pos_reg == 8'd0,
        "byte count not cleared after report end")

endmodule

`default_nettype wire
